// File: rtl/gwm_pkg.sv
`default_nettype none

package gwm_pkg;

   // Pattern capacity and the widths that follow from it.
   localparam int PATTERN_MAX = 63;
   localparam int POS_W       = PATTERN_MAX + 1;
   localparam int LEN_W       = $clog2(POS_W);

   typedef logic [1:0]                   kind_type;
   typedef logic [7:0]                   byte_type;
   typedef logic [LEN_W-1:0]             len_type;
   typedef logic [POS_W-1:0]             pos_set_type;
   typedef logic [PATTERN_MAX-1:0][7:0]  pattern_type;

   // Item kinds.
   localparam kind_type KIND_PATTERN = 2'd0;
   localparam kind_type KIND_TEXT    = 2'd1;
   localparam kind_type KIND_END     = 2'd2;
   localparam kind_type KIND_CLEAR   = 2'd3;

   // Wildcard bytes.
   localparam byte_type CH_STAR = 8'h2A;
   localparam byte_type CH_ANY  = 8'h3F;

endpackage

`default_nettype wire

// File: rtl/gwm_advance.sv
`default_nettype none

// Star closure and one-byte advance of the active position set.
module gwm_advance (
   input  wire gwm_pkg::pattern_type pattern,
   input  wire gwm_pkg::len_type     len,
   input  wire gwm_pkg::pos_set_type active,
   input  wire gwm_pkg::byte_type    ch,
   output gwm_pkg::pos_set_type      closure,
   output gwm_pkg::pos_set_type      next_set
);

   gwm_pkg::pos_set_type star_vec;
   gwm_pkg::pos_set_type step_vec;
   gwm_pkg::pos_set_type gen_vec;
   gwm_pkg::pos_set_type carry_vec;
   logic [gwm_pkg::POS_W:0] sum;

   // Per-position decode; positions at or beyond the length never fire.
   always_comb begin
      star_vec = '0;
      step_vec = '0;
      for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
         if (gwm_pkg::len_type'(i) < len) begin
            star_vec[i] = (pattern[i] == gwm_pkg::CH_STAR);
            step_vec[i] = (pattern[i] != gwm_pkg::CH_STAR) &&
                          ((pattern[i] == gwm_pkg::CH_ANY) || (pattern[i] == ch));
         end
      end
   end

   // The closure is a carry chain: generate where a star is reached,
   // propagate across stars. One adder resolves the whole chain.
   assign gen_vec   = active & star_vec;
   assign sum       = {1'b0, gen_vec} + {1'b0, star_vec};
   assign carry_vec = sum[gwm_pkg::POS_W-1:0] ^ gen_vec ^ star_vec;
   assign closure   = active | carry_vec;

   // A reached star stays; a reached literal or '?' that matches moves on.
   assign next_set  = (closure & star_vec) | ((closure & step_vec) << 1);

endmodule

`default_nettype wire

// File: rtl/glob_wildcard_matcher_unit.sv
`default_nettype none

// Channel  | Direction | Ports                               | Moves
// req      | in        | req_valid req_stall req_kind req_ch | one command or byte item
// rsp      | out       | rsp_valid rsp_stall rsp_matched     | one verdict item per end
//          |           | rsp_overflow                        |
//
// An accepted item sits in the input register and is executed from there, so an
// end item's verdict is registered in the result register once it executes.
// Sustained rate is one item per cycle, set by the closure adder, unless an end item is held.
// An end item waits in the input register only while an earlier verdict is
// stalled; all other kinds execute regardless of the result side.
// Synchronous reset clears the length, overflow flag, text progress and valid flags, not the bytes.
module glob_wildcard_matcher_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire [1:0]           req_kind,
   input  wire [7:0]           req_ch,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic                rsp_matched,
   output logic                rsp_overflow
);

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   gwm_pkg::kind_type    in_kind_ff;
   gwm_pkg::byte_type    in_ch_ff;

   // Block state.
   gwm_pkg::pattern_type pattern_ff;
   gwm_pkg::len_type     len_ff, len_in;
   gwm_pkg::pos_set_type active_ff, active_in;
   logic                 ovf_ff, ovf_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   gwm_pkg::pos_set_type closure;
   gwm_pkg::pos_set_type next_set;
   logic                 exec;
   logic                 exec_end;
   logic                 append_ok;

   gwm_advance u_advance (
      .pattern  (pattern_ff),
      .len      (len_ff),
      .active   (active_ff),
      .ch       (in_ch_ff),
      .closure  (closure),
      .next_set (next_set)
   );

   // The held item executes unless it is an end item and the result
   // register is full and stalled.
   assign exec      = in_valid_ff &&
                      ((in_kind_ff != gwm_pkg::KIND_END) || !rsp_valid_ff || !rsp_stall);
   assign exec_end  = exec && (in_kind_ff == gwm_pkg::KIND_END);
   assign req_stall = in_valid_ff && !exec;
   assign in_valid_in = req_valid || (in_valid_ff && !exec);

   assign append_ok = (len_ff < gwm_pkg::len_type'(gwm_pkg::PATTERN_MAX));

   always_comb begin
      len_in    = len_ff;
      active_in = active_ff;
      ovf_in    = ovf_ff;
      if (exec) begin
         case (in_kind_ff)
            gwm_pkg::KIND_PATTERN: begin
               if (append_ok) begin
                  len_in = len_ff + gwm_pkg::len_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            gwm_pkg::KIND_TEXT: begin
               active_in = next_set;
            end
            gwm_pkg::KIND_CLEAR: begin
               len_in    = '0;
               ovf_in    = 1'b0;
               active_in = gwm_pkg::pos_set_type'(1);
            end
            gwm_pkg::KIND_END: begin
               active_in = gwm_pkg::pos_set_type'(1);
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   // A verdict counts only when the closed set reaches the pattern end and
   // no pattern byte was dropped.
   assign rsp_valid_in    = exec_end || (rsp_valid_ff && rsp_stall);
   assign rsp_matched_in  = exec_end ? (closure[len_ff] && !ovf_ff) : rsp_matched_ff;
   assign rsp_overflow_in = exec_end ? ovf_ff : rsp_overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         len_ff       <= '0;
         active_ff    <= gwm_pkg::pos_set_type'(1);
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         len_ff       <= len_in;
         active_ff    <= active_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff <= req_kind;
         in_ch_ff   <= req_ch;
      end
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   // Pattern bytes are written at the current length, one entry per append.
   always_ff @(posedge clock) begin
      for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
         if (exec && (in_kind_ff == gwm_pkg::KIND_PATTERN) && append_ok &&
             (len_ff == gwm_pkg::len_type'(i))) begin
            pattern_ff[i] <= in_ch_ff;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // A new verdict appears only after an end item has executed.
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec_end))
      else $error("verdict without an end item");

   // An overflowed pattern never reports a match.
   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> !rsp_matched_ff)
      else $error("match reported on overflowed pattern");

   // The length never passes the capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= gwm_pkg::len_type'(gwm_pkg::PATTERN_MAX))
      else $error("pattern length beyond capacity");

   // No reached position lies beyond the pattern end.
   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      (active_ff >> len_ff) <= gwm_pkg::pos_set_type'(1))
      else $error("active position beyond pattern end");

   // A clear restarts text progress, drops the overflow flag and empties the pattern.
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      exec && (in_kind_ff == gwm_pkg::KIND_CLEAR) |=>
         (active_ff == gwm_pkg::pos_set_type'(1)) && !ovf_ff && (len_ff == '0))
      else $error("clear did not restart the matcher");

endmodule

`default_nettype wire

// File: tb/glob_wildcard_matcher_unit_tb.sv
module glob_wildcard_matcher_unit_tb;

   // Upper bound of the random wait that each side draws per item.
   localparam int WAIT_MAX    = 13;
   // Limit on a run of handshake-free cycles; reaching it means the block is stuck.
   localparam int IDLE_LIMIT  = 1000;
   // Quiet cycles after the last verdict, to catch a late stray result.
   localparam int TAIL_CYCLES = 20;
   localparam int ITEM_TARGET = 1950;

   // Ordinary pattern and text letters.
   localparam gwm_pkg::byte_type LIT_A = 8'h61;
   localparam gwm_pkg::byte_type LIT_B = 8'h62;

   typedef struct packed {
      gwm_pkg::kind_type kind;
      gwm_pkg::byte_type ch;
   } req_item_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic [7:0] req_ch   = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_matched;
   logic rsp_overflow;

   glob_wildcard_matcher_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_ch       (req_ch),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_matched  (rsp_matched),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Items waiting to be driven, and the verdicts the matcher still owes us.
   req_item_type pending_q[$];
   verdict_type  verdict_q[$];

   // Our own copy of the matcher state. Bit i of reached_set means pattern
   // position i has been reached, before any star closure is applied.
   gwm_pkg::byte_type    pat_mem [gwm_pkg::PATTERN_MAX];
   int                   pat_len     = 0;
   gwm_pkg::pos_set_type reached_set = gwm_pkg::pos_set_type'(1);
   logic                 pat_over    = 1'b0;

   int   mismatches  = 0;
   int   idle_cycles = 0;
   logic req_taken   = 1'b0;
   logic rsp_taken   = 1'b0;

   // Idle behavior: a calm side never waits, so there are stretches of
   // back-to-back traffic between the stretches of random gaps.
   int gap_left   = 0;
   int stall_left = 3;
   bit req_calm   = 1'b0;
   bit rsp_calm   = 1'b0;

   // The pattern as the stimulus generator knows it, capped at capacity.
   gwm_pkg::byte_type pat_q[$];
   int                planned = 0;

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, WAIT_MAX);
   endfunction

   // A star that is reached also reaches the position after it. Stars are
   // walked from low to high, so a chain of stars closes in one pass.
   function automatic gwm_pkg::pos_set_type close_stars(gwm_pkg::pos_set_type s);
      for (int i = 0; i < pat_len; i++) begin
         if (s[i] && pat_mem[i] == gwm_pkg::CH_STAR) s[i + 1] = 1'b1;
      end
      return s;
   endfunction

   // One text byte moves every reached position: a star holds its place,
   // while a question mark or an equal byte steps to the next position.
   function automatic gwm_pkg::pos_set_type step_text(gwm_pkg::pos_set_type s,
                                                      gwm_pkg::byte_type c);
      gwm_pkg::pos_set_type nxt;
      nxt = '0;
      s = close_stars(s);
      for (int i = 0; i < pat_len; i++) begin
         if (s[i]) begin
            if (pat_mem[i] == gwm_pkg::CH_STAR) nxt[i] = 1'b1;
            else if (pat_mem[i] == gwm_pkg::CH_ANY || pat_mem[i] == c) nxt[i + 1] = 1'b1;
         end
      end
      return nxt;
   endfunction

   // Apply one accepted item to our copy of the state. An end item queues
   // the verdict that the matcher must return for it.
   task automatic track_item(gwm_pkg::kind_type kind, gwm_pkg::byte_type ch);
      gwm_pkg::pos_set_type s;
      verdict_type          v;
      case (kind)
         gwm_pkg::KIND_PATTERN: begin
            if (pat_len < gwm_pkg::PATTERN_MAX) begin
               pat_mem[pat_len] = ch;
               pat_len++;
            end else begin
               pat_over = 1'b1;
            end
         end
         gwm_pkg::KIND_TEXT: begin
            reached_set = step_text(reached_set, ch);
         end
         gwm_pkg::KIND_CLEAR: begin
            pat_len     = 0;
            pat_over    = 1'b0;
            reached_set = gwm_pkg::pos_set_type'(1);
         end
         gwm_pkg::KIND_END: begin
            s = close_stars(reached_set);
            v.matched  = s[pat_len] && !pat_over;
            v.overflow = pat_over;
            verdict_q = {verdict_q, v};
            reached_set = gwm_pkg::pos_set_type'(1);
         end
         default: begin
         end
      endcase
   endtask

   // Monitor: everything is sampled at the rising edge. Inputs were driven
   // at the falling edge and outputs change only after the edge, so the
   // values seen here are settled.
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $error("verdict with none expected: matched %0b overflow %0b",
                      rsp_matched, rsp_overflow);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_matched !== want.matched) begin
                  $error("matched: expected %0b, actual %0b", want.matched, rsp_matched);
                  mismatches++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0b, actual %0b", want.overflow, rsp_overflow);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) track_item(req_kind, req_ch);

         // The watchdog restarts on any handshake on either side.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("glob_wildcard_matcher_unit_tb: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Driver: an item stays on the request ports until it is taken. After
   // that the driver waits its drawn gap before it offers the next item.
   always @(negedge clock) begin
      req_item_type item;
      if (!reset && !(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_q.size() != 0) begin
            item = pending_q.pop_front();
            req_valid <= 1'b1;
            req_kind  <= item.kind;
            req_ch    <= item.ch;
            gap_left  <= draw_wait(req_calm);
            if ($urandom_range(0, 63) == 0) req_calm <= !req_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: after each verdict is taken a new stall length is drawn.
   // The stall only counts down while a verdict is offered, so every verdict
   // really waits out its stall.
   always @(negedge clock) begin
      int n;
      if (rsp_taken) begin
         n = draw_wait(rsp_calm);
         rsp_stall  <= (n != 0);
         stall_left <= (n > 0) ? n - 1 : 0;
         if ($urandom_range(0, 15) == 0) rsp_calm <= !rsp_calm;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid) stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Queue one item for the driver and keep the generator's pattern in step.
   task automatic add_item(gwm_pkg::kind_type k, gwm_pkg::byte_type c);
      req_item_type item;
      item.kind = k;
      item.ch   = c;
      pending_q = {pending_q, item};
      planned++;
      if (k == gwm_pkg::KIND_CLEAR) pat_q.delete();
      else if (k == gwm_pkg::KIND_PATTERN && pat_q.size() < gwm_pkg::PATTERN_MAX)
         pat_q = {pat_q, c};
   endtask

   // Pattern bytes lean on wildcards and a small alphabet so that texts
   // built for them match often.
   function automatic gwm_pkg::byte_type glob_byte();
      case ($urandom_range(0, 9))
         0, 1:    return gwm_pkg::CH_STAR;
         2:       return gwm_pkg::CH_ANY;
         3, 4:    return LIT_A;
         5:       return LIT_B;
         default: return gwm_pkg::byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic gwm_pkg::byte_type text_byte();
      case ($urandom_range(0, 4))
         0, 1:    return LIT_A;
         2:       return LIT_B;
         default: return gwm_pkg::byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Build a text from the current pattern: a star becomes a short random
   // run, a question mark one random byte, anything else itself. Unless a
   // match is aimed at, some positions are dropped, replaced or padded.
   task automatic add_text(bit aim);
      int run;
      int pick;
      foreach (pat_q[i]) begin
         pick = aim ? 3 : $urandom_range(0, 11);
         if (pick == 1) add_item(gwm_pkg::KIND_TEXT, text_byte());
         if (pick == 2) add_item(gwm_pkg::KIND_TEXT, text_byte());
         if (pick == 0 || pick == 1) continue;
         if (pat_q[i] == gwm_pkg::CH_STAR) begin
            run = $urandom_range(0, 3);
            repeat (run) add_item(gwm_pkg::KIND_TEXT, text_byte());
         end else if (pat_q[i] == gwm_pkg::CH_ANY) begin
            add_item(gwm_pkg::KIND_TEXT, text_byte());
         end else begin
            add_item(gwm_pkg::KIND_TEXT, pat_q[i]);
         end
      end
   endtask

   initial begin
      gwm_pkg::byte_type c;
      int                len;
      bit                first_pass;

      // Directed part. An empty pattern against an empty text matches,
      // and against any text it does not.
      add_item(gwm_pkg::KIND_END, 8'hFF);
      add_item(gwm_pkg::KIND_TEXT, 8'h00);
      add_item(gwm_pkg::KIND_END, 8'h00);
      // A pattern of stars alone matches the empty text and any other.
      add_item(gwm_pkg::KIND_PATTERN, gwm_pkg::CH_STAR);
      add_item(gwm_pkg::KIND_PATTERN, gwm_pkg::CH_STAR);
      add_item(gwm_pkg::KIND_END, 8'h55);
      add_item(gwm_pkg::KIND_TEXT, 8'hFF);
      add_item(gwm_pkg::KIND_TEXT, 8'h00);
      add_item(gwm_pkg::KIND_END, 8'hAA);
      // A question mark and the extreme byte values, matched byte-exact.
      add_item(gwm_pkg::KIND_CLEAR, 8'hFF);
      add_item(gwm_pkg::KIND_PATTERN, gwm_pkg::CH_ANY);
      add_item(gwm_pkg::KIND_PATTERN, 8'hFF);
      add_item(gwm_pkg::KIND_PATTERN, 8'h00);
      add_item(gwm_pkg::KIND_END, 8'h00);
      add_item(gwm_pkg::KIND_TEXT, 8'h80);
      add_item(gwm_pkg::KIND_TEXT, 8'hFF);
      add_item(gwm_pkg::KIND_TEXT, 8'h00);
      add_item(gwm_pkg::KIND_END, 8'h0F);
      add_item(gwm_pkg::KIND_TEXT, 8'h7F);
      add_item(gwm_pkg::KIND_END, 8'hF0);
      // Pattern bytes appended in the middle of a text take effect at once.
      add_item(gwm_pkg::KIND_CLEAR, 8'h00);
      add_item(gwm_pkg::KIND_PATTERN, LIT_A);
      add_item(gwm_pkg::KIND_TEXT, LIT_A);
      add_item(gwm_pkg::KIND_PATTERN, gwm_pkg::CH_ANY);
      add_item(gwm_pkg::KIND_TEXT, LIT_B);
      add_item(gwm_pkg::KIND_END, 8'h01);

      // Random part: each pass loads a fresh pattern and checks one to five
      // texts against it. The first pass always overfills the pattern.
      first_pass = 1'b1;
      while (planned < ITEM_TARGET) begin
         add_item(gwm_pkg::KIND_CLEAR, gwm_pkg::byte_type'($urandom_range(0, 255)));
         case (first_pass ? 19 : $urandom_range(0, 19))
            18:      len = gwm_pkg::PATTERN_MAX;
            19:      len = gwm_pkg::PATTERN_MAX + $urandom_range(1, 3);
            14, 15, 16, 17: len = $urandom_range(7, 20);
            default: len = $urandom_range(0, 6);
         endcase
         first_pass = 1'b0;
         repeat (len) add_item(gwm_pkg::KIND_PATTERN, glob_byte());

         repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: add_text(1'b1);
               6, 7:             add_text(1'b0);
               8: begin
                  repeat ($urandom_range(0, 6))
                     add_item(gwm_pkg::KIND_TEXT,
                              gwm_pkg::byte_type'($urandom_range(0, 255)));
               end
               9: begin
                  // Grow the pattern mid-text by a byte that the next text
                  // byte satisfies, whatever the byte is.
                  add_text(1'b1);
                  c = glob_byte();
                  add_item(gwm_pkg::KIND_PATTERN, c);
                  add_item(gwm_pkg::KIND_TEXT, c);
               end
               default: begin
               end
            endcase
            add_item(gwm_pkg::KIND_END, gwm_pkg::byte_type'($urandom_range(0, 255)));
         end

         // Occasional noise of any kind between passes.
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4))
               add_item(gwm_pkg::kind_type'($urandom_range(0, 3)),
                        gwm_pkg::byte_type'($urandom_range(0, 255)));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Wait for every item to be taken and every verdict to come back.
      while (pending_q.size() != 0 || req_valid || verdict_q.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("glob_wildcard_matcher_unit_tb: PASS");
      end else begin
         $display("glob_wildcard_matcher_unit_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/gwm_pkg.sv
rtl/gwm_advance.sv
rtl/glob_wildcard_matcher_unit.sv
tb/glob_wildcard_matcher_unit_tb.sv
